// ===== hdl/infix_to_postfix_converter_macros.svh =====
// assertion macros for the infix to postfix converter
`ifndef INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication check
`define ITP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("itp: same-cycle check failed");
// next-cycle implication check
`define ITP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("itp: next-cycle check failed");
`else
`define ITP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ITP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/itp_pkg.sv =====
// types, character constants and code helpers for the infix to postfix converter
package itp_pkg;

   // character set
   localparam logic [7:0] CHAR_LETTER_LO = 8'd97;
   localparam logic [7:0] CHAR_LETTER_HI = 8'd122;
   localparam logic [7:0] CHAR_OPEN      = 8'h28;
   localparam logic [7:0] CHAR_CLOSE     = 8'h29;
   localparam logic [7:0] CHAR_IMP       = 8'h3E;
   localparam logic [7:0] CHAR_OR        = 8'h56;
   localparam logic [7:0] CHAR_AND       = 8'h5E;
   localparam logic [7:0] CHAR_NOT       = 8'h7E;

   // stack entry codes, ordered by rising precedence after the open paren
   typedef enum logic [2:0] {
      OP_OPEN = 3'd0,
      OP_IMP  = 3'd1,
      OP_OR   = 3'd2,
      OP_AND  = 3'd3,
      OP_NOT  = 3'd4
   } op_code_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_STRAY    = 3'd1,
      ST_UNCLOSED = 3'd2,
      ST_BAD      = 3'd3,
      ST_OVERFLOW = 3'd4
   } status_type;

   // command from the controller to the cell chain
   typedef struct packed {
      logic        push;
      logic        pop;
      op_code_type code;
   } stack_cmd_type;

   // view of the chain seen by the controller
   typedef struct packed {
      op_code_type top;
      logic        empty;
      logic        full;
   } stack_stat_type;

   // one result beat
   typedef struct packed {
      logic [7:0] char_out;
      logic       char_valid;
      status_type status;
      logic       run_last;
      logic       expr_end;
   } result_type;

   // operator character test
   function automatic logic is_operator(input logic [7:0] c);
      return (c == CHAR_IMP) || (c == CHAR_OR) || (c == CHAR_AND) || (c == CHAR_NOT);
   endfunction

   // operator character to stack code
   function automatic op_code_type char_to_code(input logic [7:0] c);
      op_code_type code;
      unique case (c)
         CHAR_IMP: code = OP_IMP;
         CHAR_OR:  code = OP_OR;
         CHAR_AND: code = OP_AND;
         CHAR_NOT: code = OP_NOT;
         default:  code = OP_OPEN;
      endcase
      return code;
   endfunction

   // stack code to output character
   function automatic logic [7:0] code_to_char(input op_code_type code);
      logic [7:0] c;
      unique case (code)
         OP_OPEN: c = CHAR_OPEN;
         OP_IMP:  c = CHAR_IMP;
         OP_OR:   c = CHAR_OR;
         OP_AND:  c = CHAR_AND;
         OP_NOT:  c = CHAR_NOT;
         default: c = 8'd0;
      endcase
      return c;
   endfunction

endpackage

// ===== hdl/itp_if.sv =====
// request and response channel interfaces of the infix to postfix converter
interface itp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       final_char;

   modport source (output valid, output char_in, output final_char, input ready);
   modport sink (input valid, input char_in, input final_char, output ready);
endinterface

interface itp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_out;
   logic       char_valid;
   logic [2:0] status;
   logic       run_last;
   logic       expr_end;

   modport source (output valid, output char_out, output char_valid, output status,
                   output run_last, output expr_end, input ready);
   modport sink (input valid, input char_out, input char_valid, input status,
                 input run_last, input expr_end, output ready);
endinterface

// ===== hdl/infix_to_postfix_converter.sv =====
// Infix to postfix converter for propositional expressions. One character is
// taken per request beat; each beat causes zero or more response beats, the
// last of which carries run_last, and the last beat of a final character also
// carries expr_end. The block takes one character at a time, and the cell
// chain shifts by one entry per cycle unless the response side stalls.
// Each character is handled as an accept state, a work state and a closing
// state; an operator first pops its higher precedence entries one by one, a
// close pops entries down to and including its open paren, and a final
// character adds a flush that pops every entry left on the stack. A stall
// on the response side holds any step that moves a beat out.
// One result is held back until the next one is known, so run_last is exact.
`include "infix_to_postfix_converter_macros.svh"

module infix_to_postfix_converter #(
   parameter int STACK_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   itp_req_if.sink    req_bus,
   itp_rsp_if.source  rsp_bus
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SINGLE = 7'b0000010,
      S_OPEN   = 7'b0000100,
      S_CLOSE  = 7'b0001000,
      S_OPER   = 7'b0010000,
      S_FLUSH  = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   localparam itp_pkg::result_type SilentResult = '{
      char_out:   8'd0,
      char_valid: 1'b0,
      status:     itp_pkg::ST_OK,
      run_last:   1'b0,
      expr_end:   1'b0
   };

   state_type               state_ff, state_in, next_raw;
   logic [7:0]              char_ff, char_in;
   logic                    fin_ff, fin_in;
   logic                    letter_ff, letter_in;
   itp_pkg::op_code_type    code_ff, code_in;
   logic                    hold_valid_ff, hold_valid_in;
   itp_pkg::result_type     hold_ff, hold_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   itp_pkg::result_type     rsp_data_ff, rsp_data_in;
   itp_pkg::stack_cmd_type  stk_cmd, cmd_raw;
   itp_pkg::stack_stat_type stk_stat;
   itp_pkg::result_type     prod_data;
   logic                    prod;
   logic                    done_send;
   logic                    step_ok;
   logic                    out_free;
   logic                    req_accept;

   itp_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (stk_cmd),
      .stat  (stk_stat)
   );

   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   assign req_accept = req_bus.valid && req_bus.ready;

   // per-state work: result produced, stack command and next state
   always_comb begin
      next_raw  = state_ff;
      cmd_raw   = '{push: 1'b0, pop: 1'b0, code: itp_pkg::OP_OPEN};
      prod      = 1'b0;
      prod_data = SilentResult;
      done_send = 1'b0;
      char_in   = char_ff;
      fin_in    = fin_ff;
      letter_in = letter_ff;
      code_in   = code_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               char_in   = req_bus.char_in;
               fin_in    = req_bus.final_char;
               letter_in = (req_bus.char_in >= itp_pkg::CHAR_LETTER_LO) &&
                           (req_bus.char_in <= itp_pkg::CHAR_LETTER_HI);
               code_in   = itp_pkg::char_to_code(req_bus.char_in);
               priority if (letter_in) begin
                  next_raw = S_SINGLE;
               end else if (req_bus.char_in == itp_pkg::CHAR_OPEN) begin
                  next_raw = S_OPEN;
               end else if (req_bus.char_in == itp_pkg::CHAR_CLOSE) begin
                  next_raw = S_CLOSE;
               end else if (itp_pkg::is_operator(req_bus.char_in)) begin
                  next_raw = S_OPER;
               end else begin
                  next_raw = S_SINGLE;
               end
            end
         end
         S_SINGLE: begin
            // letter passes straight out, anything unknown is flagged
            prod = 1'b1;
            if (letter_ff) begin
               prod_data.char_out   = char_ff;
               prod_data.char_valid = 1'b1;
            end else begin
               prod_data.status = itp_pkg::ST_BAD;
            end
            next_raw = fin_ff ? S_FLUSH : S_DONE;
         end
         S_OPEN: begin
            if (stk_stat.full) begin
               prod             = 1'b1;
               prod_data.status = itp_pkg::ST_OVERFLOW;
            end else begin
               cmd_raw.push = 1'b1;
               cmd_raw.code = itp_pkg::OP_OPEN;
            end
            next_raw = fin_ff ? S_FLUSH : S_DONE;
         end
         S_CLOSE: begin
            // pop down to the nearest open paren
            if (stk_stat.empty) begin
               prod             = 1'b1;
               prod_data.status = itp_pkg::ST_STRAY;
               next_raw         = fin_ff ? S_FLUSH : S_DONE;
            end else begin
               cmd_raw.pop = 1'b1;
               if (stk_stat.top == itp_pkg::OP_OPEN) begin
                  next_raw = fin_ff ? S_FLUSH : S_DONE;
               end else begin
                  prod                 = 1'b1;
                  prod_data.char_out   = itp_pkg::code_to_char(stk_stat.top);
                  prod_data.char_valid = 1'b1;
               end
            end
         end
         S_OPER: begin
            // pop higher precedence entries, then push
            if (!stk_stat.empty && (stk_stat.top != itp_pkg::OP_OPEN) &&
                (stk_stat.top > code_ff)) begin
               cmd_raw.pop          = 1'b1;
               prod                 = 1'b1;
               prod_data.char_out   = itp_pkg::code_to_char(stk_stat.top);
               prod_data.char_valid = 1'b1;
            end else begin
               if (stk_stat.full) begin
                  prod             = 1'b1;
                  prod_data.status = itp_pkg::ST_OVERFLOW;
               end else begin
                  cmd_raw.push = 1'b1;
                  cmd_raw.code = code_ff;
               end
               next_raw = fin_ff ? S_FLUSH : S_DONE;
            end
         end
         S_FLUSH: begin
            // empty the stack at the end of the expression
            if (stk_stat.empty) begin
               next_raw = S_DONE;
            end else begin
               cmd_raw.pop = 1'b1;
               prod        = 1'b1;
               if (stk_stat.top == itp_pkg::OP_OPEN) begin
                  prod_data.status = itp_pkg::ST_UNCLOSED;
               end else begin
                  prod_data.char_out   = itp_pkg::code_to_char(stk_stat.top);
                  prod_data.char_valid = 1'b1;
               end
            end
         end
         S_DONE: begin
            done_send = hold_valid_ff || fin_ff;
            next_raw  = S_IDLE;
         end
         default: begin
            next_raw = S_IDLE;
         end
      endcase
   end

   // a step that moves a beat to the output waits for the output register
   assign step_ok = ((prod && hold_valid_ff) || done_send) ? out_free : 1'b1;

   // commit the step, move held beat to the output register
   always_comb begin
      state_in      = state_ff;
      stk_cmd       = '{push: 1'b0, pop: 1'b0, code: itp_pkg::OP_OPEN};
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in   = rsp_data_ff;

      if (step_ok) begin
         state_in = next_raw;
         stk_cmd  = cmd_raw;
         if (prod) begin
            if (hold_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = hold_ff;
            end
            hold_valid_in = 1'b1;
            hold_in       = prod_data;
         end
         if (done_send) begin
            rsp_valid_in         = 1'b1;
            rsp_data_in          = hold_valid_ff ? hold_ff : SilentResult;
            rsp_data_in.run_last = 1'b1;
            rsp_data_in.expr_end = fin_ff;
            hold_valid_in        = 1'b0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      char_ff     <= char_in;
      fin_ff      <= fin_in;
      letter_ff   <= letter_in;
      code_ff     <= code_in;
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
   end

   // channel ports
   assign req_bus.ready      = (state_ff == S_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.char_out   = rsp_data_ff.char_out;
   assign rsp_bus.char_valid = rsp_data_ff.char_valid;
   assign rsp_bus.status     = rsp_data_ff.status;
   assign rsp_bus.run_last   = rsp_data_ff.run_last;
   assign rsp_bus.expr_end   = rsp_data_ff.expr_end;

   // checks
   `ITP_ASSERT_IMPLY(a_no_push_when_full, clock, reset, stk_cmd.push, !stk_stat.full)
   `ITP_ASSERT_IMPLY(a_no_pop_when_empty, clock, reset, stk_cmd.pop, !stk_stat.empty)
   `ITP_ASSERT_IMPLY(a_idle_holds_nothing, clock, reset, state_ff == S_IDLE, !hold_valid_ff)
   `ITP_ASSERT_NEXT(a_final_beat_sent, clock, reset,
      (state_ff == S_DONE) && fin_ff && out_free,
      rsp_valid_ff && rsp_data_ff.expr_end && rsp_data_ff.run_last)

endmodule

// ===== hdl/itp_cell.sv =====
// one stack cell: holds an operator code and shifts with its neighbors
module itp_cell (
   input  logic                  clock,
   input  itp_pkg::stack_cmd_type cmd,
   input  itp_pkg::op_code_type  above_code,
   input  itp_pkg::op_code_type  below_code,
   output itp_pkg::op_code_type  code
);

   itp_pkg::op_code_type code_ff;

   // push shifts down from above, pop shifts up from below
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         code_ff <= above_code;
      end else if (cmd.pop) begin
         code_ff <= below_code;
      end
   end

   assign code = code_ff;

endmodule

// ===== hdl/itp_stack.sv =====
// operator stack built as a chain of shifting cells with an occupancy count
module itp_stack #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  itp_pkg::stack_cmd_type  cmd,
   output itp_pkg::stack_stat_type stat
);

   localparam int CountWidth = $clog2(STACK_DEPTH + 1);

   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   itp_pkg::op_code_type  cell_code [STACK_DEPTH];

   // cell chain, top of stack in cell 0
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      itp_pkg::op_code_type above_code;
      itp_pkg::op_code_type below_code;

      if (i == 0) begin : g_top
         assign above_code = cmd.code;
      end else begin : g_inner_above
         assign above_code = cell_code[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_bottom
         assign below_code = cell_code[i];
      end else begin : g_inner_below
         assign below_code = cell_code[i+1];
      end

      itp_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .above_code (above_code),
         .below_code (below_code),
         .code       (cell_code[i])
      );
   end

   // occupancy count
   always_comb begin
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + CountWidth'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // status toward the controller
   assign stat.top   = cell_code[0];
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CountWidth'(STACK_DEPTH));

endmodule
